// File: src/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int ARENA_BYTES_DEF  = 65536;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int MAX_SEGMENTS_DEF = 64;

  localparam int OFF_W  = 16;
  localparam int SIZE_W = 17;
  localparam int IDX_W  = 8;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_NO_FIT   = 3'd2,
    ST_FREED    = 3'd3,
    ST_UNKNOWN  = 3'd4
  } stat_t;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_SET_FREE = 3'd1,
    OP_SET_USED = 3'd2,
    OP_SPLIT    = 3'd3,
    OP_MERGE    = 3'd4
  } op_t;

  typedef struct packed {
    logic              valid;
    logic              free;
    logic [OFF_W-1:0]  start;
    logic [SIZE_W-1:0] size;
  } seg_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic              is_free_cmd;
    logic [SIZE_W-1:0] req;
    logic [OFF_W-1:0]  off;
  } cell_ctl_t;

endpackage

// File: src/ffsa_if.sv
// ----------------------------------------------------------------------------
// ffsa_in_if / ffsa_out_if
// Valid/ready channels of the allocator: request words and result words.
// ----------------------------------------------------------------------------
interface ffsa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [ffsa_pkg::SIZE_W-1:0]   req_size;
  logic [ffsa_pkg::OFF_W-1:0]    free_offset;
  modport source (output valid, cmd, req_size, free_offset, input ready);
  modport sink   (input valid, cmd, req_size, free_offset, output ready);
endinterface

interface ffsa_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [ffsa_pkg::OFF_W-1:0]  grant_offset;
  modport source (output valid, status, grant_offset, input ready);
  modport sink   (input valid, status, grant_offset, output ready);
endinterface

// File: src/first_fit_segment_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_core
// First-fit arena allocator with splitting and coalescing of free segments.
// ----------------------------------------------------------------------------
// Usage: in_ch carries request words (cmd 0 allocate req_size bytes, cmd 1
// free the segment at free_offset). out_ch returns one result word per
// request: status and, for a grant, the payload offset.
// The table is a row of MAX_SEGMENTS cells in address order; each cell
// compares itself to the request and shifts to or from its neighbors.
// Sequence from accept to result valid: match, first-one pick, decode,
// three table update passes, output load. One request is in flight at a
// time, so a new word is not accepted until the last one is done; in_ch.ready
// is high only while the sequencer is idle.
// Reset: one free segment of ARENA_BYTES - HEADER_BYTES at offset 0,
// all other cells empty, no result pending.
// Receiver stall: the result word holds on out_ch until taken; a finished
// request waits for the output register before the next is accepted.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_core #(
  parameter int ARENA_BYTES  = ffsa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ffsa_in_if.sink   in_ch,
  ffsa_out_if.source out_ch
);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [ffsa_pkg::SIZE_W-1:0] HDR = ffsa_pkg::SIZE_W'(HEADER_BYTES);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SRCH = 8'b00000010,
    S_PICK = 8'b00000100,
    S_DEC  = 8'b00001000,
    S_AP1  = 8'b00010000,
    S_AP2  = 8'b00100000,
    S_AP3  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t                      state, state_next;
  logic                        cmd;
  logic [ffsa_pkg::SIZE_W-1:0] req;
  logic [ffsa_pkg::OFF_W-1:0]  off;
  logic [MAX_SEGMENTS-1:0]     hit, hit_w, first, sel;
  logic                        found, split, lf, rf;
  logic [ffsa_pkg::IDX_W-1:0]  p, p_next;
  logic [CW-1:0]               cnt;
  ffsa_pkg::stat_t             stat;
  logic [ffsa_pkg::OFF_W-1:0]  goff;
  logic                        bad;
  ffsa_pkg::cell_ctl_t         ctl;
  ffsa_pkg::seg_t              seg [MAX_SEGMENTS];
  ffsa_pkg::seg_t              size_mux;
  logic                        lf_w, rf_w, split_w;
  logic                        out_valid;
  logic [2:0]                  out_status;
  logic [ffsa_pkg::OFF_W-1:0]  out_goff;

  assign bad = !cmd && ((req == '0) || (req > ffsa_pkg::SIZE_W'(ARENA_BYTES)));

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    ffsa_pkg::seg_t pv, nx;
    if (k == 0) begin : g_first
      assign pv = '0;
    end else begin : g_mid
      assign pv = seg[k-1];
    end
    if (k == MAX_SEGMENTS - 1) begin : g_last
      assign nx = '0;
    end else begin : g_inner
      assign nx = seg[k+1];
    end
    ffsa_cell #(
      .IDX(k), .ARENA_BYTES(ARENA_BYTES), .HEADER_BYTES(HEADER_BYTES)
    ) u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .prev(pv), .next(nx),
      .seg(seg[k]), .hit(hit_w[k])
    );
  end

  assign first = hit & (~hit + 1'b1);

  always_comb begin
    p_next   = '0;
    size_mux = '0;
    lf_w     = 1'b0;
    rf_w     = 1'b0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      if (first[k]) p_next = p_next | ffsa_pkg::IDX_W'(k);
      if (sel[k]) size_mux = size_mux | seg[k];
      if (k + 1 < MAX_SEGMENTS) begin
        if (sel[k+1] && seg[k].free) lf_w = 1'b1;
      end
      if (k > 0) begin
        if (sel[k-1] && seg[k].valid && seg[k].free) rf_w = 1'b1;
      end
    end
    split_w = (cnt < CW'(MAX_SEGMENTS))
              && ({1'b0, size_mux.size} > ({1'b0, req} + {1'b0, HDR}));
  end

  always_comb begin
    ctl.is_free_cmd = cmd;
    ctl.req         = req;
    ctl.off         = off;
    ctl.idx         = (state == S_AP3) ? p - 1'b1 : p;
    ctl.op          = ffsa_pkg::OP_NONE;
    case (state)
      S_AP1: if (found) begin
        if (cmd) ctl.op = ffsa_pkg::OP_SET_FREE;
        else if (split) ctl.op = ffsa_pkg::OP_SPLIT;
        else ctl.op = ffsa_pkg::OP_SET_USED;
      end
      S_AP2: if (found && cmd && rf) ctl.op = ffsa_pkg::OP_MERGE;
      S_AP3: if (found && cmd && lf) ctl.op = ffsa_pkg::OP_MERGE;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid) state_next = S_SRCH;
      S_SRCH: state_next = S_PICK;
      S_PICK: state_next = S_DEC;
      S_DEC:  state_next = S_AP1;
      S_AP1:  state_next = S_AP2;
      S_AP2:  state_next = S_AP3;
      S_AP3:  state_next = S_DONE;
      S_DONE: if (!out_valid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!out_valid || out_ch.ready)) begin
        out_valid  <= 1'b1;
        out_status <= stat;
        out_goff   <= goff;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.op == ffsa_pkg::OP_SPLIT) cnt <= cnt + 1'b1;
      else if (ctl.op == ffsa_pkg::OP_MERGE) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd <= in_ch.cmd;
        req <= in_ch.req_size;
        off <= in_ch.free_offset;
      end
      S_SRCH: hit <= hit_w & {MAX_SEGMENTS{~bad}};
      S_PICK: begin
        sel   <= first;
        found <= |hit;
        p     <= p_next;
      end
      S_DEC: begin
        split <= split_w;
        lf    <= lf_w;
        rf    <= rf_w;
        goff  <= '0;
        if (cmd) begin
          stat <= found ? ffsa_pkg::ST_FREED : ffsa_pkg::ST_UNKNOWN;
        end else if (bad) begin
          stat <= ffsa_pkg::ST_BAD_SIZE;
        end else if (!found) begin
          stat <= ffsa_pkg::ST_NO_FIT;
        end else begin
          stat <= ffsa_pkg::ST_GRANTED;
          goff <= size_mux.start + HDR[ffsa_pkg::OFF_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.grant_offset = out_goff;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt >= CW'(1) && cnt <= CW'(MAX_SEGMENTS)) else $error("segment count out of range");
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    seg[0].valid) else $error("first segment lost");
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == S_SRCH) else $error("accept without search");
  a_goff_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ffsa_pkg::ST_GRANTED |-> out_goff == '0)
    else $error("offset on non-grant");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    ctl.op == ffsa_pkg::OP_SPLIT |-> !cmd && found && split)
    else $error("split outside grant");
endmodule

// File: src/ffsa_cell.sv
// ----------------------------------------------------------------------------
// ffsa_cell
// One segment table entry; matches the request and shifts with neighbors.
// ----------------------------------------------------------------------------
module ffsa_cell #(
  parameter int IDX          = 0,
  parameter int ARENA_BYTES  = ffsa_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffsa_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ffsa_pkg::cell_ctl_t ctl,
  input  ffsa_pkg::seg_t      prev,
  input  ffsa_pkg::seg_t      next,
  output ffsa_pkg::seg_t      seg,
  output logic                hit
);
  localparam logic [ffsa_pkg::SIZE_W-1:0] HDR = ffsa_pkg::SIZE_W'(HEADER_BYTES);
  localparam logic [ffsa_pkg::IDX_W:0]    ME  = (ffsa_pkg::IDX_W+1)'(IDX);

  logic [ffsa_pkg::IDX_W:0] at;
  logic [ffsa_pkg::IDX_W:0] at1;

  assign at  = {1'b0, ctl.idx};
  assign at1 = at + 1'b1;

  always_comb begin
    if (ctl.is_free_cmd) begin
      hit = seg.valid && (({1'b0, seg.start} + HDR) == {1'b0, ctl.off});
    end else begin
      hit = seg.valid && seg.free && (seg.size >= ctl.req);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      if (IDX == 0) begin
        seg.valid <= 1'b1;
        seg.free  <= 1'b1;
        seg.start <= '0;
        seg.size  <= ffsa_pkg::SIZE_W'(ARENA_BYTES - HEADER_BYTES);
      end else begin
        seg <= '0;
      end
    end else begin
      case (ctl.op)
        ffsa_pkg::OP_SET_FREE: if (ME == at) seg.free <= 1'b1;
        ffsa_pkg::OP_SET_USED: if (ME == at) seg.free <= 1'b0;
        ffsa_pkg::OP_SPLIT: begin
          if (ME == at) begin
            seg.size <= ctl.req;
            seg.free <= 1'b0;
          end else if (ME == at1) begin
            seg.valid <= 1'b1;
            seg.free  <= 1'b1;
            seg.start <= prev.start + HDR[ffsa_pkg::OFF_W-1:0]
                         + ctl.req[ffsa_pkg::OFF_W-1:0];
            seg.size  <= prev.size - ctl.req - HDR;
          end else if (ME > at1) begin
            seg <= prev;
          end
        end
        ffsa_pkg::OP_MERGE: begin
          if (ME == at) begin
            seg.size <= seg.size + HDR + next.size;
          end else if (ME > at) begin
            seg <= next;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
